>>> hdl/sacc_pkg.sv
// Shared types and constants of the set-associative cache tag controller.
// Used by the controller, the datapath and the top level; depends on nothing.
package sacc_pkg;

  // Default geometry.
  localparam int NUM_SETS_DEF    = 64;
  localparam int WAYS_DEF        = 4;
  localparam int BLOCK_BYTES_DEF = 32;

  // Access kinds.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;
  localparam logic [1:0] KIND_PROBE = 2'd3;

  // Replacement policies; the unused code behaves as LRU.
  localparam logic [1:0] POL_LRU    = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;

  // Configuration register indexes.
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_WTHRU  = 1'b1;

  // Galois LFSR.
  localparam logic [15:0] LFSR_SEED = 16'h0001;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one reset row in the clearing pass
    logic load;    // take the input word and read its set
    logic finish;  // update the set and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // clearing pass is at the last set
    logic out_busy;    // result register holds a word that is stalled
  } sts_t;

endpackage

>>> hdl/sacc_ctrl.sv
// Controller state machine of the cache tag controller.
// Depends on sacc_pkg for the command and status structs.
module sacc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sacc_pkg::sts_t sts,
  output sacc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state, state_next;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (sts.clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_LOOK;
      ST_LOOK:  if (!sts.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Commands and the input stall.
  assign in_stall   = (state != ST_IDLE);
  assign cmd.clear  = (state == ST_CLEAR);
  assign cmd.load   = (state == ST_IDLE) && in_valid;
  assign cmd.finish = (state == ST_LOOK) && !sts.out_busy;

endmodule

>>> hdl/sacc_dpath.sv
// Datapath of the cache tag controller: set memory, lookup, replacement,
// LFSR, configuration and result registers. Depends on sacc_pkg.
module sacc_dpath #(
  parameter int NUM_SETS    = sacc_pkg::NUM_SETS_DEF,
  parameter int WAYS        = sacc_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES = sacc_pkg::BLOCK_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  sacc_pkg::cmd_t cmd,
  output sacc_pkg::sts_t sts,
  input  logic           wr_en,
  input  logic           wr_index,
  input  logic [1:0]     wr_data,
  input  logic [1:0]     kind,
  input  logic [31:0]    addr,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           hit,
  output logic           evicted_valid,
  output logic [31:0]    victim_addr,
  output logic           victim_writeback,
  output logic           fill_read,
  output logic           through_write,
  output logic [31:0]    block_addr
);

  localparam int SSH   = $clog2(BLOCK_BYTES);
  localparam int TSH   = SSH + $clog2(NUM_SETS);
  localparam int TAG_W = 32 - TSH;
  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // One memory row holds a whole set.
  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            vld;
    logic [WAYS-1:0]            dty;
    logic [WAYS-1:0][WAY_W-1:0] ord;  // position 0 is the most recent way
  } row_t;

  row_t set_mem [NUM_SETS];

  row_t              rd_row, new_row, rst_row;
  logic [SET_W-1:0]  clr_idx, set_in, set_q;
  logic [1:0]        kind_q;
  logic [31:0]       addr_q;
  logic [TAG_W-1:0]  tag_q;
  logic [1:0]        policy;
  logic              wthru;
  logic [15:0]       lfsr, lfsr_step;

  // Results of the lookup.
  logic              found, miss_alloc, rand_pol, lru_like, is_rw;
  logic [WAY_W-1:0]  hit_way, vic_way, sel_way, pos;
  logic [WAYS-1:0]   hit_vec;
  logic              r_evict, r_wb, r_thru;
  logic [31:0]       r_vaddr;

  // Reset value of a row.
  always_comb begin
    rst_row = '0;
    for (int i = 0; i < WAYS; i++) begin
      rst_row.ord[i] = WAY_W'(WAYS - 1 - i);
    end
  end

  assign set_in = SET_W'((addr >> SSH) & 32'(NUM_SETS - 1));
  assign tag_q  = TAG_W'(addr_q >> TSH);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= sacc_pkg::POL_LRU;
      wthru  <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        sacc_pkg::REG_POLICY: policy <= wr_data;
        sacc_pkg::REG_WTHRU:  wthru  <= wr_data[0];
        default:              policy <= policy;
      endcase
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst)            clr_idx <= '0;
    else if (cmd.clear) clr_idx <= clr_idx + SET_W'(1);
  end
  assign sts.clear_last = (clr_idx == SET_W'(NUM_SETS - 1));

  // Input word capture and registered set read.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      addr_q <= addr;
      set_q  <= set_in;
      rd_row <= set_mem[set_in];
    end
  end

  // Set write: reset rows during the clearing pass, else the updated row.
  always_ff @(posedge clk) begin
    if (cmd.clear)       set_mem[clr_idx] <= rst_row;
    else if (cmd.finish) set_mem[set_q]   <= new_row;
  end

  assign lfsr_step = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? sacc_pkg::LFSR_TAPS : 16'h0000);

  // Tag compare, victim choice and row update.
  always_comb begin
    hit_vec  = '0;
    hit_way  = '0;
    pos      = WAY_W'(WAYS - 1);
    new_row  = rd_row;
    r_evict  = 1'b0;
    r_wb     = 1'b0;
    r_thru   = 1'b0;
    r_vaddr  = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = rd_row.vld[w] && (rd_row.tag[w] == tag_q);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_W'(w);
    end
    found      = |hit_vec;
    is_rw      = (kind_q == sacc_pkg::KIND_READ) || (kind_q == sacc_pkg::KIND_WRITE);
    rand_pol   = (policy == sacc_pkg::POL_RANDOM);
    lru_like   = (policy != sacc_pkg::POL_FIFO) && !rand_pol;
    miss_alloc = is_rw && !found;
    vic_way    = rand_pol ? WAY_W'(32'(lfsr_step) & 32'(WAYS - 1))
                          : rd_row.ord[WAYS-1];
    sel_way    = found ? hit_way : vic_way;

    // Position of the selected way in the recency order.
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (rd_row.ord[p] == sel_way) pos = WAY_W'(p);
    end

    if (kind_q == sacc_pkg::KIND_FLUSH) begin
      if (found) begin
        r_vaddr = (32'(rd_row.tag[hit_way]) << TSH) | (32'(set_q) << SSH);
        r_wb    = rd_row.dty[hit_way];
        new_row.vld[hit_way] = 1'b0;
        new_row.dty[hit_way] = 1'b0;
        // Move the way to the least recent end.
        for (int i = 0; i < WAYS - 1; i++) begin
          if (i >= int'(pos)) new_row.ord[i] = rd_row.ord[i+1];
        end
        new_row.ord[WAYS-1] = hit_way;
      end
    end else if (is_rw) begin
      // Move the way to the most recent end on an LRU hit or a non-random miss.
      if ((found && lru_like) || (!found && !rand_pol)) begin
        for (int i = 1; i < WAYS; i++) begin
          if (i <= int'(pos)) new_row.ord[i] = rd_row.ord[i-1];
        end
        new_row.ord[0] = sel_way;
      end
      if (!found) begin
        if (rd_row.vld[vic_way]) begin
          r_evict = 1'b1;
          r_vaddr = (32'(rd_row.tag[vic_way]) << TSH) | (32'(set_q) << SSH);
          r_wb    = rd_row.dty[vic_way];
        end
        new_row.tag[vic_way] = tag_q;
        new_row.vld[vic_way] = 1'b1;
        new_row.dty[vic_way] = 1'b0;
      end
      if (kind_q == sacc_pkg::KIND_WRITE) begin
        if (wthru) r_thru = 1'b1;
        else       new_row.dty[sel_way] = 1'b1;
      end
    end
  end

  // LFSR steps on each random-policy read or write miss.
  always_ff @(posedge clk) begin
    if (rst)                                  lfsr <= sacc_pkg::LFSR_SEED;
    else if (cmd.finish && miss_alloc && rand_pol) lfsr <= lfsr_step;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit              <= found;
      evicted_valid    <= r_evict;
      victim_addr      <= r_vaddr;
      victim_writeback <= r_wb;
      fill_read        <= miss_alloc;
      through_write    <= r_thru;
      block_addr       <= addr_q & ~32'(BLOCK_BYTES - 1);
    end
  end

  assign sts.out_busy = out_valid && out_stall;

endmodule

>>> hdl/set_assoc_cache_tag_controller.sv
// Top level of the set-associative cache tag controller.
// Depends on sacc_pkg, sacc_ctrl and sacc_dpath.
//
// Each accepted word (read, write, flush block or probe at a byte address)
// yields exactly one result word. An item has two steps: reading the set's row
// (tags, valid and dirty bits, recency order) from the set memory into a
// register, then comparing, choosing a victim and writing the row back; the
// second step waits while a stalled result holds the result register. After
// reset a clearing pass writes every set once, during which no input word is
// taken; configuration writes are taken at any time. The result register lets
// a finished word wait while the next item is taken.
module set_assoc_cache_tag_controller #(
  parameter int NUM_SETS    = sacc_pkg::NUM_SETS_DEF,
  parameter int WAYS        = sacc_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES = sacc_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [1:0]  wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic        evicted_valid,
  output logic [31:0] victim_addr,
  output logic        victim_writeback,
  output logic        fill_read,
  output logic        through_write,
  output logic [31:0] block_addr
);

  sacc_pkg::cmd_t cmd;
  sacc_pkg::sts_t sts;

  sacc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacc_dpath #(
    .NUM_SETS    (NUM_SETS),
    .WAYS        (WAYS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .kind             (kind),
    .addr             (addr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hit              (hit),
    .evicted_valid    (evicted_valid),
    .victim_addr      (victim_addr),
    .victim_writeback (victim_writeback),
    .fill_read        (fill_read),
    .through_write    (through_write),
    .block_addr       (block_addr)
  );

endmodule

>>> hdl/sacc_checker.sv
// Port-level checks of the cache tag controller and their bind.
// Depends only on the top level's ports.
module sacc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic        evicted_valid,
  input logic        fill_read,
  input logic [31:0] block_addr
);

  // An accepted word holds the input off for its lookup cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken during lookup");

  // With the result register empty, the result shows after the row read and the lookup, not during the lookup.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid ##1 out_valid)
    else $error("result not delivered on time");

  // A fill only follows a miss, and an eviction only a fill.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!fill_read || !hit) && (!evicted_valid || fill_read))
    else $error("inconsistent result flags");

  // A stalled result stays.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(block_addr) && $stable(hit))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_tag_controller sacc_checker u_sacc_checker (.*);
